// ----- rtl/core/life_automaton_grid_engine_defines.svh -----
// Assertion macros for the grid engine checker.
`ifndef LIFE_AUTOMATON_GRID_ENGINE_DEFINES_SVH
`define LIFE_AUTOMATON_GRID_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define LAGE_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define LAGE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/core/lage_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lage_pkg;

	localparam int GRID_COLUMNS_DEF = 128;
	localparam int GRID_ROWS_DEF    = 128;

	localparam int OPCODE_W   = 3;
	localparam int COORD_W    = 7;
	localparam int INTERVAL_W = 8;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd10;

	localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_TOGGLE = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_PLAY   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

	// B3/S23 neighbour counts
	localparam logic [3:0] NBR_BIRTH = 4'd3;
	localparam logic [3:0] NBR_KEEP  = 4'd2;

endpackage

`default_nettype wire

// ----- rtl/core/life_automaton_grid_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Conway B3/S23 engine on a bounded GRID_ROWS x GRID_COLUMNS grid held in one row-wide
// synchronous memory; cells off the grid are dead. One request is taken at a time and
// gives exactly one response. Read, toggle-running and paused ticks pass through a read
// state and a response state; a toggle first reads the row and writes it back toggled
// when on the grid. A running tick first works out the bit-serial counter remainder and,
// when it steps, streams the rows through a three-row window (one memory read and one
// write-back a cycle). Clear and the pass after reset sweep the memory one row a cycle,
// during which no request is taken; interval writes are always taken.
// A finished response sits in an output register, so the next request may be taken
// while it waits.
module life_automaton_grid_engine #(
	parameter int GRID_COLUMNS = lage_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = lage_pkg::GRID_ROWS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            generation_interval_we,
	input  wire logic [lage_pkg::INTERVAL_W-1:0] generation_interval,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [lage_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic [lage_pkg::COORD_W-1:0]    cell_x,
	input  wire logic [lage_pkg::COORD_W-1:0]    cell_y,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 cell_alive,
	output logic                                 running,
	output logic                                 generation_done
);
	import lage_pkg::*;

	localparam int RAW = $clog2(GRID_ROWS);
	localparam int CW  = $clog2(GRID_COLUMNS);
	localparam int GW  = $clog2(GRID_ROWS + 2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_GEN  = 3'd2;
	localparam logic [2:0] ST_TOGR = 3'd3;
	localparam logic [2:0] ST_TOGW = 3'd4;
	localparam logic [2:0] ST_RD   = 3'd5;
	localparam logic [2:0] ST_RSP  = 3'd6;
	localparam logic [2:0] ST_CLR  = 3'd7;

	logic [2:0]            state_q;
	logic [GW-1:0]         gidx_q;
	logic                  resp_q;
	logic                  run_q;
	logic [INTERVAL_W-1:0] counter_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [2:0]            bitcnt_q;
	logic                  done_q;
	logic                  out_valid_q;
	logic                  cell_alive_q;
	logic                  running_q;
	logic                  gen_done_q;

	logic [COORD_W-1:0]    x_q;
	logic [COORD_W-1:0]    y_q;
	logic [INTERVAL_W-1:0] dvd_q;
	logic [INTERVAL_W-1:0] rem_q;
	logic [GRID_COLUMNS-1:0] up_q;
	logic [GRID_COLUMNS-1:0] mid_q;

	logic [GRID_COLUMNS-1:0] cell_mem_q [GRID_ROWS];
	logic [GRID_COLUMNS-1:0] rdata_q;

	logic                    mem_we;
	logic [RAW-1:0]          mem_waddr;
	logic [GRID_COLUMNS-1:0] mem_wdata;
	logic [RAW-1:0]          mem_raddr;

	logic [RAW-1:0] y_idx;
	logic [CW-1:0]  col_idx;
	logic           on_grid;
	logic           accept;
	logic           out_free;

	logic [INTERVAL_W:0]   rem_sh;
	logic [INTERVAL_W:0]   divisor;
	logic [INTERVAL_W:0]   rem_nx;
	logic [INTERVAL_W-1:0] iv_eff;

	logic [GRID_COLUMNS-1:0] below;
	logic [GRID_COLUMNS+1:0] up_p;
	logic [GRID_COLUMNS+1:0] mid_p;
	logic [GRID_COLUMNS+1:0] dn_p;
	logic [GRID_COLUMNS-1:0] next_row;

	assign y_idx    = RAW'(y_q);
	assign col_idx  = CW'(x_q);
	assign on_grid  = (int'(x_q) < GRID_COLUMNS) && (int'(y_q) < GRID_ROWS);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign cell_alive      = cell_alive_q;
	assign running         = running_q;
	assign generation_done = gen_done_q;

	// remainder of counter by interval, one dividend bit a cycle
	assign iv_eff  = (interval_q == '0) ? INTERVAL_W'(1) : interval_q;
	assign divisor = {1'b0, iv_eff};
	assign rem_sh  = {rem_q, dvd_q[INTERVAL_W-1]};
	assign rem_nx  = (rem_sh >= divisor) ? (rem_sh - divisor) : rem_sh;

	// three-row window
	assign below = (gidx_q <= GW'(GRID_ROWS)) ? rdata_q : '0;
	assign up_p  = {1'b0, up_q, 1'b0};
	assign mid_p = {1'b0, mid_q, 1'b0};
	assign dn_p  = {1'b0, below, 1'b0};

	always_comb begin
		logic [3:0] n;
		n = '0;
		for (int c = 0; c < GRID_COLUMNS; c++) begin
			n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2]) + 4'(mid_p[c]) +
				4'(mid_p[c+2]) + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
			next_row[c] = (n == NBR_BIRTH) || (mid_q[c] && (n == NBR_KEEP));
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = y_idx;
		mem_wdata = rdata_q ^ (GRID_COLUMNS'(1) << col_idx);
		mem_raddr = y_idx;
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = RAW'(gidx_q);
				mem_wdata = '0;
			end
			ST_TOGW: begin
				mem_we = on_grid;
			end
			ST_GEN: begin
				mem_we    = (gidx_q >= GW'(2));
				mem_waddr = RAW'(gidx_q - GW'(2));
				mem_wdata = next_row;
				if (gidx_q < GW'(GRID_ROWS)) begin
					mem_raddr = RAW'(gidx_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= cell_mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			gidx_q       <= '0;
			resp_q       <= 1'b0;
			run_q        <= 1'b0;
			counter_q    <= '0;
			interval_q   <= INTERVAL_RESET;
			bitcnt_q     <= '0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			cell_alive_q <= 1'b0;
			running_q    <= 1'b0;
			gen_done_q   <= 1'b0;
		end else begin
			if (generation_interval_we) begin
				interval_q <= generation_interval;
			end
			if (out_valid_q && out_ready && state_q != ST_RSP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q <= 1'b0;
						unique case (opcode)
							OP_TICK: begin
								if (run_q) begin
									bitcnt_q <= '0;
									state_q  <= ST_MOD;
								end else begin
									state_q <= ST_RD;
								end
							end
							OP_TOGGLE: state_q <= ST_TOGR;
							OP_PLAY: begin
								run_q   <= !run_q;
								state_q <= ST_RD;
							end
							OP_CLEAR: begin
								run_q   <= 1'b0;
								gidx_q  <= '0;
								resp_q  <= 1'b1;
								state_q <= ST_CLR;
							end
							default: state_q <= ST_RD;
						endcase
					end
				end
				ST_MOD: begin
					bitcnt_q <= bitcnt_q + 3'd1;
					if (bitcnt_q == 3'd7) begin
						if (rem_nx == '0) begin
							counter_q <= INTERVAL_W'(1);
							done_q    <= 1'b1;
							gidx_q    <= '0;
							state_q   <= ST_GEN;
						end else begin
							counter_q <= counter_q + INTERVAL_W'(1);
							state_q   <= ST_RD;
						end
					end
				end
				ST_GEN: begin
					gidx_q <= gidx_q + GW'(1);
					if (gidx_q == GW'(GRID_ROWS + 1)) begin
						state_q <= ST_RD;
					end
				end
				ST_TOGR: state_q <= ST_TOGW;
				ST_TOGW: state_q <= ST_RD;
				ST_RD:   state_q <= ST_RSP;
				ST_RSP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						cell_alive_q <= on_grid && rdata_q[col_idx];
						running_q    <= run_q;
						gen_done_q   <= done_q;
						state_q      <= ST_IDLE;
					end
				end
				ST_CLR: begin
					gidx_q <= gidx_q + GW'(1);
					if (gidx_q == GW'(GRID_ROWS - 1)) begin
						state_q <= resp_q ? ST_RD : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= cell_x;
			y_q   <= cell_y;
			dvd_q <= counter_q;
			rem_q <= '0;
		end
		if (state_q == ST_MOD) begin
			rem_q <= INTERVAL_W'(rem_nx);
			dvd_q <= {dvd_q[INTERVAL_W-2:0], 1'b0};
		end
		if (state_q == ST_MOD && bitcnt_q == 3'd7) begin
			up_q  <= '0;
			mid_q <= '0;
		end
		if (state_q == ST_GEN && gidx_q != '0) begin
			up_q  <= mid_q;
			mid_q <= below;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lage_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "life_automaton_grid_engine_defines.svh"

module lage_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic cell_alive,
	input wire logic running,
	input wire logic generation_done
);
	import lage_pkg::*;

	logic out_stall;
	logic in_take;

	assign out_stall = out_valid && !out_ready;
	assign in_take   = in_valid && in_ready;

	`LAGE_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "response dropped while stalled")
	`LAGE_ASSERT_NEXT(a_out_stable, out_stall, $stable(cell_alive) && $stable(running) && $stable(generation_done), "response changed while stalled")
	`LAGE_ASSERT_NOW(a_done_running, out_valid && generation_done, running, "generation reported while paused")
	`LAGE_ASSERT_NEXT(a_one_at_a_time, in_take, !in_ready, "second request taken while busy")

endmodule

bind life_automaton_grid_engine lage_checker u_lage_checker (.*);

`default_nettype wire
